[rtl/fixed_partition_first_fit_allocator_core_assert.svh]
// assertion macros for the partition allocator checker
`ifndef FIXED_PARTITION_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define FIXED_PARTITION_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH
// implication checked on every clock unless reset is low
`define FPA_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
// implication checked on the following clock
`define FPA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

[rtl/fpa_pkg.sv]
// types and constants shared by the partition allocator
package fpa_pkg;
    localparam int NumPart = 16;
    localparam int MaxJobs = 32;
    localparam int PartW = $clog2(NumPart);
    localparam int JobW = $clog2(MaxJobs);

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_SUBMIT = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam logic [1:0] KIND_DONE = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_SUM = 2'd2;
    localparam logic [1:0] KIND_ACK = 2'd3;

    localparam logic [1:0] PH_EMPTY = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_RUN = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  block_index;
        logic [15:0] amount;
        logic [7:0]  duration;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  job_index;
        logic [3:0]  block_index_out;
        logic [4:0]  placed_count;
        logic [5:0]  queue_length;
        logic [19:0] fragmentation;
        logic [15:0] time_value;
        logic [20:0] wait_sum;
        logic        all_done;
        logic        error;
        logic        last;
    } t_res;

    // job table entry
    typedef struct packed {
        logic [15:0] size;
        logic [7:0]  dur;
        logic [15:0] end_time;
    } t_job;
endpackage

[rtl/fixed_partition_first_fit_allocator_core.sv]
// top level of the first-fit fixed-partition allocator
// load and submit: busy for one cycle, the single result follows in the next cycle
// tick: completion pass over the table jobs, placement pass scanning up to 16
//   partitions per waiting job, fragmentation pass over partitions, then the summary
// results come one per cycle at most and cannot be stalled by the receiver
// synchronous active-low reset clears control state, phases, busy flags and sizes
module fixed_partition_first_fit_allocator_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  fpa_pkg::t_req   i_req,
    output logic            o_res_valid,
    output fpa_pkg::t_res   o_res
);
    import fpa_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_ACK   = 9'b000000010,
        S_CRD   = 9'b000000100,
        S_CCHK  = 9'b000001000,
        S_PRD   = 9'b000010000,
        S_PCHK  = 9'b000100000,
        S_FRD   = 9'b001000000,
        S_FADD  = 9'b010000000,
        S_SUM   = 9'b100000000
    } t_state;

    t_state r_state;
    t_req   r_req;

    // job table memory with a registered read port
    t_job job_mem [MaxJobs];
    t_job r_job_rd;
    logic [JobW-1:0] r_rd_addr;
    logic            n_we;
    logic [JobW-1:0] n_wa;
    t_job            n_wd;

    // partition and phase state in flops
    logic [15:0]     r_psize [NumPart];
    logic [NumPart-1:0] r_pbusy;
    logic [JobW-1:0] r_powner [NumPart];
    logic [1:0]      r_phase [MaxJobs];

    logic [15:0] r_time;
    logic [5:0]  r_jcount;
    logic [5:0]  r_wcount;
    logic [20:0] r_wsum;
    logic [5:0]  r_j;
    logic [PartW:0] r_m;
    logic [4:0]  r_placed;
    logic [19:0] r_frag;

    logic        r_vld;
    t_res        r_res;

    logic [JobW-1:0] jj;
    logic [PartW-1:0] mm;
    assign jj = r_j[JobW-1:0];
    assign mm = r_m[PartW-1:0];

    // memory port
    always_ff @(posedge i_clk) begin
        if (n_we) job_mem[n_wa] <= n_wd;
        r_job_rd <= job_mem[r_rd_addr];
    end

    assign busy = (r_state != S_IDLE);
    assign o_res_valid = r_vld;
    assign o_res = r_res;

    // owner match search for a completing job
    logic [PartW-1:0] own_m;
    always_comb begin
        own_m = '0;
        for (int k = NumPart - 1; k >= 0; k--) begin
            if (r_pbusy[k] && r_powner[k] == jj) own_m = PartW'(k);
        end
    end

    // active job present
    logic any_active;
    always_comb begin
        any_active = 1'b0;
        for (int k = 0; k < MaxJobs; k++) begin
            if (r_phase[k] == PH_WAIT || r_phase[k] == PH_RUN) any_active = 1'b1;
        end
    end

    logic [15:0] end_t;
    assign end_t = r_time + {8'd0, r_job_rd.dur};

    // current partition is free and large enough
    logic fit;
    assign fit = !r_pbusy[mm] && (r_psize[mm] >= r_job_rd.size);

    // memory write: new job on submit, end time on placement
    always_comb begin
        n_we = 1'b0;
        n_wa = jj;
        n_wd = r_job_rd;
        n_wd.end_time = end_t;
        if (r_state == S_ACK && r_req.opcode == OP_SUBMIT && r_jcount < 6'(MaxJobs)) begin
            n_we = 1'b1;
            n_wa = r_jcount[JobW-1:0];
            n_wd.size = r_req.amount;
            n_wd.dur = r_req.duration;
            n_wd.end_time = '0;
        end else if (r_state == S_PCHK && fit) begin
            n_we = 1'b1;
        end
    end

    // controller
    always_ff @(posedge i_clk) begin
        logic n_vld;
        t_res n_res;
        n_vld = 1'b0;
        n_res = '0;
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_state <= S_IDLE;
            r_pbusy <= '0;
            r_time <= '0;
            r_jcount <= '0;
            r_wcount <= '0;
            r_wsum <= '0;
            for (int k = 0; k < NumPart; k++) r_psize[k] <= '0;
            for (int k = 0; k < MaxJobs; k++) r_phase[k] <= PH_EMPTY;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req <= i_req;
                        r_j <= '0;
                        r_m <= '0;
                        r_placed <= '0;
                        r_frag <= '0;
                        r_rd_addr <= '0;
                        r_state <= (i_req.opcode == OP_TICK) ? S_CRD : S_ACK;
                    end
                end
                S_ACK: begin
                    n_res.kind = KIND_ACK;
                    n_res.last = 1'b1;
                    if (r_req.opcode == OP_LOAD) begin
                        n_res.block_index_out = r_req.block_index;
                        if (!r_pbusy[r_req.block_index])
                            r_psize[r_req.block_index] <= r_req.amount;
                    end else if (r_req.opcode == OP_SUBMIT) begin
                        if (r_jcount < 6'(MaxJobs)) begin
                            r_phase[r_jcount[JobW-1:0]] <= PH_WAIT;
                            r_jcount <= r_jcount + 6'd1;
                            r_wcount <= r_wcount + 6'd1;
                            n_res.job_index = r_jcount[4:0];
                        end else begin
                            n_res.error = 1'b1;
                        end
                    end
                    n_vld = 1'b1;
                    r_state <= S_IDLE;
                end
                // completion pass: read entry, then check
                S_CRD: begin
                    if (r_j >= r_jcount) begin
                        r_j <= '0;
                        r_rd_addr <= '0;
                        r_state <= S_PRD;
                    end else begin
                        r_rd_addr <= jj;
                        r_state <= S_CCHK;
                    end
                end
                S_CCHK: begin
                    if (r_phase[jj] == PH_RUN && r_job_rd.end_time == r_time) begin
                        r_pbusy[own_m] <= 1'b0;
                        r_phase[jj] <= PH_DONE;
                        n_res.kind = KIND_DONE;
                        n_res.job_index = 5'(jj);
                        n_res.block_index_out = 4'(own_m);
                        n_res.time_value = r_time;
                        n_vld = 1'b1;
                    end
                    r_j <= r_j + 6'd1;
                    r_rd_addr <= jj + JobW'(1);
                    r_state <= S_CRD;
                end
                // placement pass: each waiting job scans partitions one per cycle
                S_PRD: begin
                    if (r_j >= r_jcount) begin
                        r_m <= '0;
                        r_rd_addr <= r_powner[0];
                        r_state <= S_FRD;
                    end else if (r_phase[jj] != PH_WAIT) begin
                        r_j <= r_j + 6'd1;
                        r_rd_addr <= jj + JobW'(1);
                    end else begin
                        r_rd_addr <= jj;
                        r_m <= '0;
                        r_state <= S_PCHK;
                    end
                end
                S_PCHK: begin
                    if (fit) begin
                        r_pbusy[mm] <= 1'b1;
                        r_powner[mm] <= jj;
                        r_phase[jj] <= PH_RUN;
                        r_wsum <= r_wsum + {5'd0, r_time};
                        if (r_wcount != '0) r_wcount <= r_wcount - 6'd1;
                        r_placed <= r_placed + 5'd1;
                        n_res.kind = KIND_ALLOC;
                        n_res.job_index = 5'(jj);
                        n_res.block_index_out = 4'(mm);
                        n_res.time_value = end_t;
                        n_vld = 1'b1;
                        r_j <= r_j + 6'd1;
                        r_rd_addr <= jj + JobW'(1);
                        r_state <= S_PRD;
                    end else if (r_m == (PartW+1)'(NumPart - 1)) begin
                        r_j <= r_j + 6'd1;
                        r_rd_addr <= jj + JobW'(1);
                        r_state <= S_PRD;
                    end else begin
                        r_m <= r_m + (PartW+1)'(1);
                    end
                end
                // fragmentation pass over partitions
                S_FRD: begin
                    if (r_m == (PartW+1)'(NumPart)) begin
                        r_state <= S_SUM;
                    end else begin
                        r_state <= S_FADD;
                    end
                end
                S_FADD: begin
                    if (r_pbusy[mm] && r_psize[mm] >= r_job_rd.size)
                        r_frag <= r_frag + 20'(r_psize[mm] - r_job_rd.size);
                    r_m <= r_m + (PartW+1)'(1);
                    r_rd_addr <= r_powner[mm + PartW'(1)];
                    r_state <= S_FRD;
                end
                S_SUM: begin
                    n_res.kind = KIND_SUM;
                    n_res.placed_count = r_placed;
                    n_res.queue_length = r_wcount;
                    n_res.fragmentation = r_frag;
                    n_res.time_value = r_time;
                    n_res.wait_sum = r_wsum;
                    n_res.all_done = !any_active;
                    n_res.last = 1'b1;
                    n_vld = 1'b1;
                    r_time <= r_time + 16'd1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            r_vld <= n_vld;
            if (n_vld) r_res <= n_res;
        end
    end
endmodule

[rtl/fpa_checker.sv]
// port-level checker for the partition allocator
`include "fixed_partition_first_fit_allocator_core_assert.svh"
module fpa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_res_valid,
    input fpa_pkg::t_res o_res
);
    import fpa_pkg::*;
    `FPA_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `FPA_ASSERT_IMP(a_last_idle, i_clk, i_rst_n, o_res_valid && o_res.last, !busy || $past(busy))
    `FPA_ASSERT_IMP(a_last_ends, i_clk, i_rst_n, o_res_valid && o_res.last, !busy)
    `FPA_ASSERT_IMP(a_res_busy, i_clk, i_rst_n, o_res_valid, $past(busy))
endmodule

bind fixed_partition_first_fit_allocator_core fpa_checker u_fpa_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_res_valid(o_res_valid), .o_res(o_res)
);
